// ===== src/acs_pkg.sv =====
`default_nettype none
package acs_pkg;

  localparam int CHANNELS    = 4;
  localparam int MAX_RUN     = 1024;
  localparam int SAMPLE_BITS = 12;

  localparam int CH_W    = 2;
  localparam int LEN_W   = $clog2(MAX_RUN) + 1;
  localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_RUN);
  localparam int STEP_W  = $clog2(SUM_W);
  localparam int DB_W    = 12;
  localparam int GAIN_W  = 16;
  localparam int Q_FRAC  = 8;
  localparam int PROD_W  = SAMPLE_BITS + GAIN_W;
  localparam int MA_W    = 20;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [MA_W-1:0] CURRENT_MAX = {MA_W{1'b1}};

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALIBRATE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN            = 2'd3;

  localparam logic KIND_MEASURE   = 1'b0;
  localparam logic KIND_CALIBRATE = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0]  measure_count;
    logic [LEN_W-1:0]  calibrate_count;
    logic [DB_W-1:0]   deadband_counts;
    logic [GAIN_W-1:0] gain_q8;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic             kind;
    logic [SUM_W-1:0] sum;
    logic [LEN_W-1:0] length;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_SCALE,
    BK_FINISH
  } back_state_t;

  function automatic logic [LEN_W-1:0] clamp_count(input logic [LEN_W-1:0] c);
    logic [LEN_W-1:0] r;
    r = c;
    if (c == '0) r = LEN_W'(1);
    else if (c > LEN_W'(MAX_RUN)) r = LEN_W'(MAX_RUN);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/acs_in_if.sv =====
`default_nettype none
interface acs_in_if;
  logic                           valid;
  logic                           ready;
  logic [acs_pkg::CH_W-1:0]        channel;
  logic                           kind;
  logic [acs_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, channel, kind, sample, input ready);
  modport sink   (input valid, channel, kind, sample, output ready);
endinterface
`default_nettype wire

// ===== src/acs_out_if.sv =====
`default_nettype none
interface acs_out_if;
  logic                            valid;
  logic                            ready;
  logic [acs_pkg::CH_W-1:0]         result_channel;
  logic                            result_kind;
  logic [acs_pkg::SAMPLE_BITS-1:0]  average;
  logic [acs_pkg::MA_W-1:0]         current_ma;

  modport source (output valid, result_channel, result_kind, average, current_ma,
                  input ready);
  modport sink   (input valid, result_channel, result_kind, average, current_ma,
                  output ready);
endinterface
`default_nettype wire

// ===== src/acs_front.sv =====
`default_nettype none
module acs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  acs_pkg::cfg_t      cfg,
  acs_in_if.sink             samples,
  input  wire logic          q_full,
  output logic               push,
  output acs_pkg::job_t      push_job
);

  logic [acs_pkg::SUM_W-1:0] run_sum    [acs_pkg::CHANNELS];
  logic [acs_pkg::LEN_W-1:0] run_length [acs_pkg::CHANNELS];
  logic                      run_kind   [acs_pkg::CHANNELS];

  logic                      accept;
  logic                      in_range;
  logic                      restart;
  logic [acs_pkg::SUM_W-1:0] sum_next;
  logic [acs_pkg::LEN_W-1:0] length_next;
  logic [acs_pkg::LEN_W-1:0] target;
  logic                      done;

  assign samples.ready = !q_full;
  assign accept   = samples.valid && samples.ready;
  assign in_range = 32'(samples.channel) < acs_pkg::CHANNELS;

  always_comb begin
    // drop a run in progress when the sample kind changes
    restart = (run_length[samples.channel] != '0) &&
              (run_kind[samples.channel] != samples.kind);
    sum_next    = (restart ? '0 : run_sum[samples.channel]) +
                  acs_pkg::SUM_W'(samples.sample);
    length_next = (restart ? '0 : run_length[samples.channel]) + acs_pkg::LEN_W'(1);
    target = acs_pkg::clamp_count(samples.kind ? cfg.calibrate_count
                                               : cfg.measure_count);
    done = length_next >= target;
  end

  assign push = accept && in_range && done;
  assign push_job = '{channel: samples.channel, kind: samples.kind,
                      sum: sum_next, length: length_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < acs_pkg::CHANNELS; i++) begin
        run_sum[i]    <= '0;
        run_length[i] <= '0;
        run_kind[i]   <= 1'b0;
      end
    end else if (accept && in_range) begin
      run_kind[samples.channel] <= samples.kind;
      if (done) begin
        run_sum[samples.channel]    <= '0;
        run_length[samples.channel] <= '0;
      end else begin
        run_sum[samples.channel]    <= sum_next;
        run_length[samples.channel] <= length_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/acs_queue.sv =====
`default_nettype none
module acs_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  acs_pkg::job_t  push_job,
  output logic           full,
  input  wire logic      pop,
  output logic           pending,
  output acs_pkg::job_t  head
);

  acs_pkg::job_t              slots [acs_pkg::QUEUE_DEPTH];
  logic [acs_pkg::QPTR_W-1:0] wr_ptr;
  logic [acs_pkg::QPTR_W-1:0] rd_ptr;
  logic [acs_pkg::QCNT_W-1:0] count;
  logic                       do_push;
  logic                       do_pop;

  function automatic logic [acs_pkg::QPTR_W-1:0] advance(
    input logic [acs_pkg::QPTR_W-1:0] p);
    logic [acs_pkg::QPTR_W-1:0] r;
    r = (32'(p) == acs_pkg::QUEUE_DEPTH - 1) ? '0 : p + acs_pkg::QPTR_W'(1);
    return r;
  endfunction

  assign full    = 32'(count) == acs_pkg::QUEUE_DEPTH;
  assign pending = count != '0;
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && pending;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= advance(wr_ptr);
      if (do_pop)  rd_ptr <= advance(rd_ptr);
      case ({do_push, do_pop})
        2'b10:   count <= count + acs_pkg::QCNT_W'(1);
        2'b01:   count <= count - acs_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/acs_back.sv =====
`default_nettype none
module acs_back (
  input  wire logic      clk,
  input  wire logic      rst,
  input  acs_pkg::cfg_t  cfg,
  input  wire logic      pending,
  input  acs_pkg::job_t  head,
  output logic           pop,
  acs_out_if.source      results
);

  acs_pkg::back_state_t state;
  acs_pkg::back_state_t state_next;

  logic [acs_pkg::SAMPLE_BITS-1:0] zero_offset [acs_pkg::CHANNELS];

  logic [acs_pkg::CH_W-1:0]   job_channel;
  logic                       job_kind;
  logic [acs_pkg::SUM_W-1:0]  quo;
  logic [acs_pkg::LEN_W-1:0]  rem;
  logic [acs_pkg::LEN_W-1:0]  divisor;
  logic [acs_pkg::STEP_W-1:0] step;
  logic [acs_pkg::LEN_W:0]    trial;
  logic                       fits;
  logic                       last_step;

  logic [acs_pkg::SAMPLE_BITS-1:0] avg;
  logic [acs_pkg::SAMPLE_BITS-1:0] corrected;
  logic [acs_pkg::PROD_W-1:0]      product;
  logic                            pass;
  logic [acs_pkg::PROD_W-acs_pkg::Q_FRAC-1:0] scaled;
  logic [acs_pkg::MA_W-1:0]        ma;

  logic load_out;
  logic out_valid;

  // one quotient bit per cycle, restoring form
  assign trial     = {rem, quo[acs_pkg::SUM_W-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign last_step = 32'(step) == acs_pkg::SUM_W - 1;

  assign avg       = quo[acs_pkg::SAMPLE_BITS-1:0];
  assign corrected = (avg > zero_offset[job_channel]) ? avg - zero_offset[job_channel] : '0;
  assign scaled    = product[acs_pkg::PROD_W-1:acs_pkg::Q_FRAC];
  assign ma = (!pass) ? '0 :
              (scaled > (acs_pkg::PROD_W-acs_pkg::Q_FRAC)'(acs_pkg::CURRENT_MAX)) ?
              acs_pkg::CURRENT_MAX : acs_pkg::MA_W'(scaled);

  always_comb begin
    state_next = state;
    case (state)
      acs_pkg::BK_IDLE:   if (pending) state_next = acs_pkg::BK_DIVIDE;
      acs_pkg::BK_DIVIDE: if (last_step) state_next = acs_pkg::BK_SCALE;
      acs_pkg::BK_SCALE:  state_next = acs_pkg::BK_FINISH;
      acs_pkg::BK_FINISH: if (!out_valid || results.ready) state_next = acs_pkg::BK_IDLE;
      default:            state_next = acs_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      acs_pkg::BK_IDLE:   pop = pending;
      acs_pkg::BK_FINISH: load_out = !out_valid || results.ready;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= acs_pkg::BK_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      acs_pkg::BK_IDLE: begin
        job_channel <= head.channel;
        job_kind    <= head.kind;
        quo         <= head.sum;
        divisor     <= head.length;
        rem         <= '0;
        step        <= '0;
      end
      acs_pkg::BK_DIVIDE: begin
        rem  <= fits ? acs_pkg::LEN_W'(trial - {1'b0, divisor})
                     : trial[acs_pkg::LEN_W-1:0];
        quo  <= {quo[acs_pkg::SUM_W-2:0], fits};
        step <= step + acs_pkg::STEP_W'(1);
      end
      acs_pkg::BK_SCALE: begin
        product <= acs_pkg::PROD_W'(corrected) * acs_pkg::PROD_W'(cfg.gain_q8);
        pass    <= (job_kind == acs_pkg::KIND_MEASURE) &&
                   (corrected >= cfg.deadband_counts);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < acs_pkg::CHANNELS; i++) zero_offset[i] <= '0;
    end else if (state == acs_pkg::BK_SCALE && job_kind == acs_pkg::KIND_CALIBRATE) begin
      zero_offset[job_channel] <= avg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      results.result_channel <= job_channel;
      results.result_kind    <= job_kind;
      results.average        <= avg;
      results.current_ma     <= ma;
    end
  end

  assign results.valid = out_valid;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == acs_pkg::BK_DIVIDE |-> rem < divisor)
    else $error("divider remainder not below divisor");

  a_quotient_fits: assert property (@(posedge clk) disable iff (rst)
    state == acs_pkg::BK_SCALE |-> quo[acs_pkg::SUM_W-1:acs_pkg::SAMPLE_BITS] == '0)
    else $error("average exceeds sample range");

  a_calibrate_no_current: assert property (@(posedge clk) disable iff (rst)
    out_valid && results.result_kind == acs_pkg::KIND_CALIBRATE |->
      results.current_ma == '0)
    else $error("calibration result carries current");

  a_pop_starts_divide: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == acs_pkg::BK_DIVIDE && step == '0 && rem == '0)
    else $error("divider not started after pop");
`endif

endmodule
`default_nettype wire

// ===== src/averaged_current_sense.sv =====
`default_nettype none
// Four-channel averaging current sense. Each sample transfer on "samples" carries a
// channel, a kind (measure or calibrate) and a 12-bit ADC value; every channel sums its
// own run, and a change of kind restarts the run with the new sample. When a run reaches
// its count (0 acts as 1, above 1024 acts as 1024) one result transfer follows on
// "results": the truncated average and, for a measure run, the offset-corrected count
// (clamped at zero, zeroed below the deadband) scaled by the Q8 gain to milliamps. A
// calibrate run stores its average as the channel's zero offset and reports 0 mA.
// Samples are taken every cycle while the two-entry job queue has room; each completed
// run goes through load, divide, scale and output steps in the back end, dividing on
// the shared restoring divider (one quotient bit per cycle over the 22-bit sum). Write
// configuration only while idle; registers are measure_count, calibrate_count,
// deadband_counts and gain_q8 at indexes 0 to 3.
module averaged_current_sense (
  input  wire logic                            clk,
  input  wire logic                            rst,
  acs_in_if.sink                               samples,
  acs_out_if.source                            results,
  input  wire logic                            cfg_we,
  input  wire logic [acs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [acs_pkg::CFG_W-1:0]       cfg_data
);

  acs_pkg::cfg_t cfg;
  acs_pkg::job_t push_job;
  acs_pkg::job_t head;
  logic          push;
  logic          q_full;
  logic          pop;
  logic          pending;

  // hold configuration; reset values match the default run lengths and scaling
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.measure_count   <= acs_pkg::LEN_W'(64);
      cfg.calibrate_count <= acs_pkg::LEN_W'(200);
      cfg.deadband_counts <= acs_pkg::DB_W'(149);
      cfg.gain_q8         <= acs_pkg::GAIN_W'(5158);
    end else if (cfg_we) begin
      case (cfg_index)
        acs_pkg::REG_MEASURE_COUNT:   cfg.measure_count   <= cfg_data[acs_pkg::LEN_W-1:0];
        acs_pkg::REG_CALIBRATE_COUNT: cfg.calibrate_count <= cfg_data[acs_pkg::LEN_W-1:0];
        acs_pkg::REG_DEADBAND:        cfg.deadband_counts <= cfg_data[acs_pkg::DB_W-1:0];
        acs_pkg::REG_GAIN:            cfg.gain_q8         <= cfg_data[acs_pkg::GAIN_W-1:0];
        default:                      cfg <= cfg;
      endcase
    end
  end

  // front: accumulate runs, emit one job per completed run
  acs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .samples  (samples),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // decouple run completion from the slow divide
  acs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pending  (pending),
    .head     (head)
  );

  // back: divide, correct, scale and register the result
  acs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pending (pending),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule
`default_nettype wire

// ===== dv/averaged_current_sense_test.sv =====
`timescale 1ns / 100ps

module averaged_current_sense_test;
  import acs_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  // Quiet cycles to allow after the last result. This covers samples still
  // sitting in the input path and a full back-end pass for each queued job.
  localparam int SETTLE = 80;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 20;
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};

  // One completed run as it leaves the block.
  typedef struct packed {
    logic [CH_W-1:0]        channel;
    logic                   kind;
    logic [SAMPLE_BITS-1:0] average;
    logic [MA_W-1:0]        current_ma;
  } sense_result_t;

  // One row of the directed table: either a register write or a sample. A
  // sample row may carry a result typed in by hand.
  typedef struct {
    bit                     is_write;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_W-1:0]       value;
    logic [CH_W-1:0]        channel;
    logic                   kind;
    logic [SAMPLE_BITS-1:0] sample;
    bit                     typed;
    sense_result_t          result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  acs_in_if  samples ();
  acs_out_if results ();

  averaged_current_sense u_dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register copies, held at the widths of the block.
  logic [LEN_W-1:0]  measure_count_q;
  logic [LEN_W-1:0]  calibrate_count_q;
  logic [DB_W-1:0]   deadband_q;
  logic [GAIN_W-1:0] gain_q;

  // Per-channel run state and stored zero offsets.
  logic [SUM_W-1:0]       lane_sum    [CHANNELS];
  logic [LEN_W-1:0]       lane_len    [CHANNELS];
  logic                   lane_kind   [CHANNELS];
  logic [SAMPLE_BITS-1:0] lane_offset [CHANNELS];

  // Kind that the random traffic currently favors on each channel.
  logic next_kind [CHANNELS];

  sense_result_t expected_readings [$];
  stim_row_t     stim_table [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fails = 0;
  int unsigned cycles = 0;

  function automatic sense_result_t make_result(input logic [CH_W-1:0] ch,
      input logic kind, input logic [SAMPLE_BITS-1:0] avg, input logic [MA_W-1:0] ma);
    sense_result_t r;
    r.channel    = ch;
    r.kind       = kind;
    r.average    = avg;
    r.current_ma = ma;
    return r;
  endfunction

  // Add one sample to its channel's run. Return 1 with the result when the
  // run ends.
  function automatic bit accumulate_sample(input logic [CH_W-1:0] ch, input logic kind,
      input logic [SAMPLE_BITS-1:0] smp, output sense_result_t r);
    int unsigned target;
    int unsigned avg;
    int unsigned corrected;
    longint unsigned scaled;
    r = '0;
    // Switch kinds: drop the run in progress and start over with this sample.
    if (lane_len[ch] != '0 && lane_kind[ch] != kind) begin
      lane_sum[ch] = '0;
      lane_len[ch] = '0;
    end
    lane_kind[ch] = kind;
    lane_sum[ch]  = lane_sum[ch] + smp;
    lane_len[ch]  = lane_len[ch] + 1'b1;

    target = (kind == KIND_CALIBRATE) ? calibrate_count_q : measure_count_q;
    if (target == 0) begin
      target = 1;
    end else if (target > MAX_RUN) begin
      target = MAX_RUN;
    end
    // Compare with "at or above", since a count lowered mid-run ends the run
    // on the next sample.
    if (lane_len[ch] < target) return 1'b0;

    avg = lane_sum[ch] / lane_len[ch];
    lane_sum[ch] = '0;
    lane_len[ch] = '0;

    r.channel = ch;
    r.kind    = kind;
    r.average = avg[SAMPLE_BITS-1:0];
    if (kind == KIND_CALIBRATE) begin
      lane_offset[ch] = avg[SAMPLE_BITS-1:0];
    end else begin
      corrected = (avg > lane_offset[ch]) ? avg - lane_offset[ch] : 0;
      if (corrected >= deadband_q) begin
        scaled = (longint'(corrected) * gain_q) >> Q_FRAC;
        r.current_ma = (scaled > CURRENT_MAX) ? CURRENT_MAX : scaled[MA_W-1:0];
      end
    end
    return 1'b1;
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
      input logic [CFG_W-1:0] value);
    stim_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.index    = idx;
    row.value    = value;
    stim_table.push_back(row);
  endfunction

  function automatic void add_sample(input logic [CH_W-1:0] ch, input logic kind,
      input logic [SAMPLE_BITS-1:0] smp);
    stim_row_t row;
    row = '{default: '0};
    row.channel = ch;
    row.kind    = kind;
    row.sample  = smp;
    stim_table.push_back(row);
  endfunction

  function automatic void add_checked(input logic [CH_W-1:0] ch, input logic kind,
      input logic [SAMPLE_BITS-1:0] smp, input logic [SAMPLE_BITS-1:0] avg,
      input logic [MA_W-1:0] ma);
    add_sample(ch, kind, smp);
    stim_table[$].typed  = 1'b1;
    stim_table[$].result = make_result(ch, kind, avg, ma);
  endfunction

  // Drive one sample transfer. Record a typed result if one is given; otherwise
  // record the predicted one. Keep valid high on return so that back-to-back
  // calls stream without a bubble.
  task automatic transfer_sample(input logic [CH_W-1:0] ch, input logic kind,
      input logic [SAMPLE_BITS-1:0] smp, input bit typed = 1'b0,
      input sense_result_t typed_res = '0);
    sense_result_t predicted;
    bit has_result;
    while ($urandom_range(99) < send_idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid   <= 1'b1;
    samples.channel <= ch;
    samples.kind    <= kind;
    samples.sample  <= smp;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    has_result = accumulate_sample(ch, kind, smp, predicted);
    if (typed) begin
      expected_readings.push_back(typed_res);
    end else if (has_result) begin
      expected_readings.push_back(predicted);
    end
  endtask

  // Drop valid, wait until every pending result has arrived, then hold off.
  task automatic quiesce(input int settle);
    samples.valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write enable is held for one cycle and then dropped before the task returns,
  // so that two writes never touch cfg_we in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MEASURE_COUNT:   measure_count_q   = value[LEN_W-1:0];
      REG_CALIBRATE_COUNT: calibrate_count_q = value[LEN_W-1:0];
      REG_DEADBAND:        deadband_q        = value[DB_W-1:0];
      REG_GAIN:            gain_q            = value[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Settings for one random phase. Counts stay short so that runs end often.
  // A few phases pin one register at an extreme.
  task automatic retune(input int phase);
    logic [CFG_W-1:0] m, c, d, g;
    m = CFG_W'($urandom_range(1, 6));
    c = CFG_W'($urandom_range(1, 4));
    d = CFG_W'($urandom_range(0, 400));
    g = CFG_W'($urandom_range(0, 65535));
    case (phase)
      1: m = '0;
      2: g = {CFG_W{1'b1}};
      3: c = '0;
      5: d = CFG_W'(FULL_SCALE);
      6: g = '0;
      default: ;
    endcase
    write_reg(REG_MEASURE_COUNT, m);
    write_reg(REG_CALIBRATE_COUNT, c);
    write_reg(REG_DEADBAND, d);
    write_reg(REG_GAIN, g);
  endtask

  // Random traffic. Most samples extend a run of the kind favored on their
  // channel, and now and then a channel flips kind and drops its run. Samples
  // fall at the rails, near the stored offset, or in range (up to 800 for calibrate).
  task automatic run_traffic(input int items, input bit drain_midway);
    logic [CH_W-1:0] ch;
    logic [SAMPLE_BITS-1:0] smp;
    for (int n = 0; n < items; n++) begin
      if (drain_midway && n == items / 2) quiesce(0);
      ch = CH_W'($urandom_range(CHANNELS - 1));
      if ($urandom_range(9) == 0) next_kind[ch] = ~next_kind[ch];
      case ($urandom_range(7))
        0: smp = '0;
        1: smp = FULL_SCALE;
        2: smp = SAMPLE_BITS'(lane_offset[ch] + $urandom_range(0, 300));
        default: begin
          if (next_kind[ch] == KIND_CALIBRATE) smp = SAMPLE_BITS'($urandom_range(0, 800));
          else smp = SAMPLE_BITS'($urandom_range(0, FULL_SCALE));
        end
      endcase
      transfer_sample(ch, next_kind[ch], smp);
    end
  endtask

  // Result side: compare each transfer against the oldest expectation. Stall
  // at random with the current percentage.
  always @(posedge clk) begin : result_check
    sense_result_t want;
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        if (expected_readings.size() == 0) begin
          $error("result with nothing expected: channel %0d kind %0d average %0d mA %0d",
                 results.result_channel, results.result_kind, results.average,
                 results.current_ma);
          fails++;
        end else begin
          want = expected_readings.pop_front();
          if (results.result_channel !== want.channel) begin
            $error("result_channel: expected %0d, got %0d", want.channel,
                   results.result_channel);
            fails++;
          end
          if (results.result_kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, results.result_kind);
            fails++;
          end
          if (results.average !== want.average) begin
            $error("average: expected %0d, got %0d", want.average, results.average);
            fails++;
          end
          if (results.current_ma !== want.current_ma) begin
            $error("current_ma: expected %0d, got %0d", want.current_ma, results.current_ma);
            fails++;
          end
        end
      end
      results.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("averaged_current_sense_test failed");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    samples.valid   = 1'b0;
    samples.channel = '0;
    samples.kind    = KIND_MEASURE;
    samples.sample  = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;

    measure_count_q   = LEN_W'(64);
    calibrate_count_q = LEN_W'(200);
    deadband_q        = DB_W'(149);
    gain_q            = GAIN_W'(5158);
    for (int c = 0; c < CHANNELS; c++) begin
      lane_sum[c]    = '0;
      lane_len[c]    = '0;
      lane_kind[c]   = KIND_MEASURE;
      lane_offset[c] = '0;
      next_kind[c]   = KIND_MEASURE;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one full measure run on channel 0 against a zero offset,
    // and one full calibrate run on channel 1. Interleave the two.
    for (int i = 0; i < 200; i++) begin
      transfer_sample(1, KIND_CALIBRATE, SAMPLE_BITS'(100), i == 199,
                      make_result(1, KIND_CALIBRATE, 100, 0));
      if (i < 64)
        transfer_sample(0, KIND_MEASURE, SAMPLE_BITS'(3000), i == 63,
                        make_result(0, KIND_MEASURE, 3000, 60445));
    end

    // Directed table. Channel 1 holds an offset of 100 from above; the others
    // hold zero.
    add_write(REG_MEASURE_COUNT, 1);
    add_write(REG_CALIBRATE_COUNT, 1);
    add_write(REG_DEADBAND, 0);
    add_write(REG_GAIN, 256);
    add_checked(0, KIND_MEASURE, FULL_SCALE, FULL_SCALE, 4095);
    add_checked(0, KIND_MEASURE, 0, 0, 0);
    add_checked(2, KIND_CALIBRATE, FULL_SCALE, FULL_SCALE, 0);
    // Below the stored offset: clamp at zero.
    add_checked(2, KIND_MEASURE, 100, 100, 0);
    add_checked(3, KIND_CALIBRATE, 7, 7, 0);
    add_checked(3, KIND_MEASURE, 7, 7, 0);
    add_write(REG_GAIN, 16'hFFFF);
    add_checked(0, KIND_MEASURE, FULL_SCALE, FULL_SCALE, 1048304);
    add_write(REG_GAIN, 0);
    add_checked(0, KIND_MEASURE, FULL_SCALE, FULL_SCALE, 0);
    // Widest deadband: only a full-scale corrected value gets through.
    add_write(REG_DEADBAND, CFG_W'(FULL_SCALE));
    add_write(REG_GAIN, 256);
    add_checked(0, KIND_MEASURE, 4094, 4094, 0);
    add_checked(0, KIND_MEASURE, FULL_SCALE, FULL_SCALE, 4095);
    add_write(REG_DEADBAND, 10);
    add_write(REG_MEASURE_COUNT, 3);
    add_write(REG_CALIBRATE_COUNT, 2);
    // Kind change: drop the measure run and average only the calibrate pair.
    add_sample(1, KIND_MEASURE, 50);
    add_sample(1, KIND_MEASURE, 60);
    add_sample(1, KIND_CALIBRATE, 20);
    add_sample(1, KIND_CALIBRATE, 30);
    add_sample(1, KIND_MEASURE, 40);
    add_sample(1, KIND_MEASURE, 40);
    add_sample(1, KIND_MEASURE, 40);
    // Inside the deadband.
    add_sample(1, KIND_MEASURE, 30);
    add_sample(1, KIND_MEASURE, 30);
    add_sample(1, KIND_MEASURE, 30);
    // A zero count acts as one.
    add_write(REG_MEASURE_COUNT, 0);
    add_sample(2, KIND_MEASURE, 4000);
    // Lower the count mid-run: the run ends on the next sample and divides
    // by its true length of six.
    add_write(REG_MEASURE_COUNT, 8);
    for (int i = 0; i < 5; i++) add_sample(0, KIND_MEASURE, 10);
    add_write(REG_MEASURE_COUNT, 2);
    add_sample(0, KIND_MEASURE, 40);
    add_write(REG_CALIBRATE_COUNT, 0);
    add_sample(3, KIND_CALIBRATE, 9);

    send_idle_pct  = 10;
    recv_stall_pct = 10;
    foreach (stim_table[i]) begin
      if (stim_table[i].is_write) begin
        quiesce(SETTLE);
        write_reg(stim_table[i].index, stim_table[i].value);
      end else begin
        transfer_sample(stim_table[i].channel, stim_table[i].kind, stim_table[i].sample,
                        stim_table[i].typed, stim_table[i].result);
      end
    end

    // Random phases. Cycle through the idling modes: none, sender idle,
    // receiver stalling, and both lightly. Runs left open carry over into the
    // next settings.
    for (int p = 0; p < PHASES; p++) begin
      quiesce(SETTLE);
      retune(p);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 83;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct  = 10;
          recv_stall_pct = 10;
        end
      endcase
      run_traffic(PHASE_ITEMS, p == 3);
    end

    quiesce(SETTLE);
    if (fails == 0) begin
      $display("averaged_current_sense_test passed");
    end else begin
      $display("averaged_current_sense_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/acs_pkg.sv
src/acs_in_if.sv
src/acs_out_if.sv
src/acs_front.sv
src/acs_queue.sv
src/acs_back.sv
src/averaged_current_sense.sv
dv/averaged_current_sense_test.sv
